/* rtl/stkc_pkg.sv */
// Shared types and constants for the stack calculator.
package stkc_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned DEF_DEPTH   = 16;
  localparam int unsigned DIV_STEPS   = DATA_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef logic [DATA_W-1:0] word_t;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0,
    ACT_POP  = 3'd1,
    ACT_PEEK = 3'd2,
    ACT_DUP  = 3'd3,
    ACT_ADD  = 3'd4,
    ACT_SUB  = 3'd5,
    ACT_MUL  = 3'd6,
    ACT_DIV  = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_UNDER = 2'd1,
    STAT_OVER  = 2'd2,
    STAT_DIVZ  = 2'd3
  } status_t;

  // What a cell loads on a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD    = 2'd0,
    CELL_TAKE_UP = 2'd1,
    CELL_TAKE_DN = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/stkc_if.sv */
// Handshake interfaces for the calculator's item and result channels.
interface stkc_in_if;
  import stkc_pkg::*;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface stkc_out_if;
  import stkc_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  logic [4:0]         entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input result_value, input status, input entry_count,
                  output ready);
endinterface

/* rtl/stkc_cell.sv */
// One stack cell: holds an entry and loads from either neighbour.
module stkc_cell import stkc_pkg::*; (
  input  logic     clk,
  input  cell_op_t op,
  input  word_t    up_data,
  input  word_t    dn_data,
  output word_t    data
);

  word_t data_r;

  always_ff @(posedge clk) begin
    unique case (op)
      CELL_TAKE_UP: data_r <= up_data;
      CELL_TAKE_DN: data_r <= dn_data;
      default:      data_r <= data_r;
    endcase
  end

  assign data = data_r;

endmodule

/* rtl/stkc_div.sv */
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
module stkc_div import stkc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  word_t     dividend,
  input  word_t     divisor,
  output word_t     quotient,
  output div_stat_t stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  word_t                rem_r, quo_r, dvs_r;
  logic                 neg_r;
  word_t                a_mag, b_mag;
  logic [DATA_W:0]      trial;

  assign a_mag = dividend[DATA_W-1] ? (~dividend + word_t'(1)) : dividend;
  assign b_mag = divisor[DATA_W-1]  ? (~divisor + word_t'(1))  : divisor;
  assign trial = {rem_r, quo_r[DATA_W-1]} - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
    end else if (busy_r) begin
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // The dividend shifts out of the quotient register as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= a_mag;
      dvs_r <= b_mag;
      neg_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!trial[DATA_W]) begin
        rem_r <= trial[DATA_W-1:0];
        quo_r <= {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], quo_r[DATA_W-1]};
        quo_r <= {quo_r[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg_r ? (~quo_r + word_t'(1)) : quo_r;
  assign stat     = '{busy: busy_r, done: done_r};

endmodule

/* rtl/stack_calculator_core.sv */
// Stack calculator: a row of shifting cells holds the stack with its top in the first cell.
// An item is taken only when the block is idle, so a new item waits until the last one's
// result is loaded into the output register. Push, pop, peek, dup, add, sub and mul load
// their result from the execute state; a div without error runs the divider, which produces
// one quotient bit per cycle, and loads its quotient from a finish state. A finished result
// waits in the output register while the next item is taken in; an item whose result
// cannot yet be loaded stalls the input until that register frees. Push and dup shift the
// row down by one cell; pop shifts it up; an arithmetic action shifts it up and writes its
// result into the top cell. On an error the stack is unchanged.
module stack_calculator_core import stkc_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  stkc_in_if.sink    in_ch,
  stkc_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_DIV  = 2'd2,
    S_FIN  = 2'd3
  } state_t;

  state_t         state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  action_t        act_r;
  word_t          val_r;
  logic           out_valid_r, out_valid_nxt;
  word_t          out_res_r, out_res_nxt;
  status_t        out_status_r, out_status_nxt;

  word_t          cell_q [STACK_DEPTH];
  word_t          top_w, nxt_w, load_data, quo_w;
  cell_op_t       op_top, op_rest;
  logic           out_free, commit, div_start;
  div_stat_t      div_st;
  status_t        ex_status;
  word_t          ex_res;
  logic           empty, full, under2;
  logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

  assign top_w    = cell_q[0];
  assign nxt_w    = cell_q[1];
  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == CNT_W'(STACK_DEPTH));
  assign under2   = (cnt_r < CNT_W'(2));
  assign out_free = !out_valid_r || out_ch.ready;

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    word_t    up_d;
    word_t    dn_d;
    cell_op_t op;
    if (i == 0) begin : g_top
      assign up_d = load_data;
      assign op   = op_top;
    end else begin : g_body
      assign up_d = cell_q[i-1];
      assign op   = op_rest;
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign dn_d = '0;
    end else begin : g_inner
      assign dn_d = cell_q[i+1];
    end
    stkc_cell u_cell (
      .clk     (clk),
      .op      (op),
      .up_data (up_d),
      .dn_data (dn_d),
      .data    (cell_q[i])
    );
  end

  stkc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (top_w),
    .divisor  (nxt_w),
    .quotient (quo_w),
    .stat     (div_st)
  );

  // Outcome of the held item, from the top two cells and the count.
  always_comb begin
    ex_status = STAT_OK;
    ex_res    = '0;
    unique case (act_r)
      ACT_PUSH: begin
        if (full) ex_status = STAT_OVER;
      end
      ACT_POP, ACT_PEEK: begin
        if (empty) ex_status = STAT_UNDER;
        else       ex_res    = top_w;
      end
      ACT_DUP: begin
        priority if (empty) ex_status = STAT_UNDER;
        else if (full)      ex_status = STAT_OVER;
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV: begin
        if (under2) begin
          ex_status = STAT_UNDER;
        end else begin
          unique case (act_r)
            ACT_ADD: ex_res = top_w + nxt_w;
            ACT_SUB: ex_res = top_w - nxt_w;
            ACT_MUL: ex_res = top_w * nxt_w;
            default: if (nxt_w == '0) ex_status = STAT_DIVZ;
          endcase
        end
      end
      default: ex_status = STAT_OK;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_res_nxt    = out_res_r;
    out_status_nxt = out_status_r;
    op_top         = CELL_HOLD;
    op_rest        = CELL_HOLD;
    load_data      = val_r;
    commit         = 1'b0;
    div_start      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (act_r == ACT_DIV && ex_status == STAT_OK) begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end else if (out_free) begin
          commit         = 1'b1;
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_res_nxt    = ex_res;
          out_status_nxt = ex_status;
          if (ex_status == STAT_OK) begin
            unique case (act_r)
              ACT_PUSH: begin
                op_top  = CELL_TAKE_UP;
                op_rest = CELL_TAKE_UP;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
              ACT_DUP: begin
                load_data = top_w;
                op_top    = CELL_TAKE_UP;
                op_rest   = CELL_TAKE_UP;
                cnt_nxt   = cnt_r + CNT_W'(1);
              end
              ACT_POP: begin
                op_top  = CELL_TAKE_DN;
                op_rest = CELL_TAKE_DN;
                cnt_nxt = cnt_r - CNT_W'(1);
              end
              ACT_ADD, ACT_SUB, ACT_MUL: begin
                load_data = ex_res;
                op_top    = CELL_TAKE_UP;
                op_rest   = CELL_TAKE_DN;
                cnt_nxt   = cnt_r - CNT_W'(1);
              end
              default: begin
                op_top  = CELL_HOLD;
                op_rest = CELL_HOLD;
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_st.done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          commit         = 1'b1;
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_res_nxt    = quo_w;
          out_status_nxt = STAT_OK;
          load_data      = quo_w;
          op_top         = CELL_TAKE_UP;
          op_rest        = CELL_TAKE_DN;
          cnt_nxt        = cnt_r - CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_res_r    <= out_res_nxt;
      out_status_r <= out_status_nxt;
      if (state_r == S_IDLE && in_ch.valid) begin
        act_r <= action_t'(in_ch.action);
        val_r <= word_t'(in_ch.value);
      end
    end
  end

  assign cnt_ext = {{COUNT_OUT_W{1'b0}}, cnt_r};

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.entry_count  = cnt_ext[COUNT_OUT_W-1:0];

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_FIN))
    else $error("result raised outside a commit");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> state_r == S_DIV)
    else $error("divider finished while not awaited");

  a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && state_r == S_EXEC && ex_status != STAT_OK) |=> $stable(cnt_r))
    else $error("count changed on an error beat");
`endif

endmodule

/* bench/tb_stack_calculator_core.sv */
// Self-checking testbench for the stack calculator core.
`timescale 1ns / 1ps

module tb_stack_calculator_core;
  import stkc_pkg::*;

  localparam int unsigned DEPTH          = DEF_DEPTH;
  localparam int unsigned RANDOM_ITEMS   = 1150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned HOLD_AFTER     = 300;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam word_t       WORD_MAX       = 32'h7fff_ffff;
  localparam word_t       WORD_MIN       = 32'h8000_0000;

  typedef struct {
    word_t      result_value;
    status_t    status;
    logic [4:0] entry_count;
  } calc_result_t;

  // Mirrors the stack and holds the results still owed by the block.
  class stack_mirror;
    word_t        cells[DEPTH];
    int unsigned  depth;
    int unsigned  taken;
    int unsigned  failures;
    calc_result_t awaited[$];

    function void take_action(action_t act, word_t val);
      calc_result_t r;
      word_t        a;
      word_t        b;
      longint       q;
      r.result_value = '0;
      r.status       = STAT_OK;
      taken++;
      case (act)
        ACT_PUSH: begin
          if (depth >= DEPTH) begin
            r.status = STAT_OVER;
          end else begin
            cells[depth] = val;
            depth++;
          end
        end
        ACT_POP, ACT_PEEK: begin
          if (depth == 0) begin
            r.status = STAT_UNDER;
          end else begin
            r.result_value = cells[depth-1];
            if (act == ACT_POP) depth--;
          end
        end
        ACT_DUP: begin
          if (depth == 0) begin
            r.status = STAT_UNDER;
          end else if (depth >= DEPTH) begin
            r.status = STAT_OVER;
          end else begin
            cells[depth] = cells[depth-1];
            depth++;
          end
        end
        default: begin
          if (depth < 2) begin
            r.status = STAT_UNDER;
          end else begin
            a = cells[depth-1];
            b = cells[depth-2];
            case (act)
              ACT_ADD: r.result_value = a + b;
              ACT_SUB: r.result_value = a - b;
              ACT_MUL: r.result_value = a * b;
              default: begin
                if (b == '0) begin
                  r.status = STAT_DIVZ;
                end else begin
                  // Worked out at 64 bits so that the most negative word over minus one wraps.
                  q = longint'($signed(a)) / longint'($signed(b));
                  r.result_value = q[31:0];
                end
              end
            endcase
            if (r.status == STAT_OK) begin
              depth--;
              cells[depth-1] = r.result_value;
            end else begin
              r.result_value = '0;
            end
          end
        end
      endcase
      r.entry_count = depth[4:0];
      awaited.push_back(r);
    endfunction

    function void check_result(word_t rv, logic [1:0] st, logic [4:0] cnt);
      calc_result_t e;
      if (awaited.size() == 0) begin
        $error("result beat with nothing outstanding: value %0d status %0d count %0d",
               $signed(rv), st, cnt);
        failures++;
        return;
      end
      e = awaited.pop_front();
      if (rv !== e.result_value) begin
        $error("result_value: expected %0d, got %0d", $signed(e.result_value), $signed(rv));
        failures++;
      end
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        failures++;
      end
      if (cnt !== e.entry_count) begin
        $error("entry_count: expected %0d, got %0d", e.entry_count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  bit          quiet;
  int unsigned stall_cycles;
  stack_mirror mirror = new();

  stkc_in_if  in_ch();
  stkc_out_if out_ch();

  stack_calculator_core #(.STACK_DEPTH(DEPTH)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic word_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      case ($urandom_range(0, 4))
        0:       return '0;
        1:       return 32'd1;
        2:       return '1;
        3:       return WORD_MIN;
        default: return WORD_MAX;
      endcase
    end
    if (r < 50) return word_t'(int'($urandom_range(0, 20)) - 10);
    return $urandom;
  endfunction

  // While climbing the stack is mostly filled, otherwise mostly consumed.
  function automatic action_t pick_action(bit climbing);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return action_t'($urandom_range(0, 7));
    if (climbing) begin
      if (r < 45) return ACT_PUSH;
      if (r < 60) return ACT_DUP;
      if (r < 68) return ACT_PEEK;
    end else begin
      if (r < 20) return ACT_PUSH;
      if (r < 27) return ACT_DUP;
      if (r < 33) return ACT_PEEK;
    end
    case ($urandom_range(0, 4))
      0:       return ACT_POP;
      1:       return ACT_ADD;
      2:       return ACT_SUB;
      3:       return ACT_MUL;
      default: return ACT_DIV;
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(input action_t act, input word_t val);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.value  <= val;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        mirror.check_result(out_ch.result_value, out_ch.status, out_ch.entry_count);
      if (in_ch.valid && in_ch.ready)
        mirror.take_action(action_t'(in_ch.action), in_ch.value);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off so that the block backs up.
  initial begin : result_sink
    bit          held;
    bit          lvl;
    int unsigned len;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (!held && mirror.taken >= HOLD_AFTER) begin
        held = 1'b1;
        lvl  = 1'b0;
        len  = HOLD_CYCLES;
      end else if (quiet) begin
        lvl = 1'b1;
        len = 1;
      end else begin
        lvl = ($urandom_range(0, 99) < 65);
        len = lvl ? $urandom_range(1, 12) : idle_len();
      end
      out_ch.ready <= lvl;
      repeat (len) @(negedge clk);
    end
  end

  initial begin : stimulus
    bit          climbing;
    int unsigned n;
    in_ch.valid  = 1'b0;
    in_ch.action = ACT_PUSH;
    in_ch.value  = '0;
    quiet        = 1'b0;
    climbing     = 1'b1;
    rst_n        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Empty stack: every reading action underflows.
    send_item(ACT_POP, '0);
    send_item(ACT_PEEK, WORD_MAX);
    send_item(ACT_DUP, WORD_MIN);
    send_item(ACT_MUL, '1);
    // One entry is not enough for arithmetic; a zero below the top makes div fail.
    send_item(ACT_PUSH, '0);
    send_item(ACT_ADD, 32'd5);
    send_item(ACT_PUSH, WORD_MAX);
    send_item(ACT_DIV, '0);
    send_item(ACT_POP, '0);
    // Most negative over minus one wraps back to itself.
    send_item(ACT_PUSH, '1);
    send_item(ACT_PUSH, WORD_MIN);
    send_item(ACT_DIV, '0);
    // Fill to the brim, then push and dup must both overflow.
    repeat (DEPTH - 2) send_item(ACT_DUP, $urandom);
    send_item(ACT_PUSH, 32'h5a5a_a5a5);
    send_item(ACT_DUP, '0);
    send_item(ACT_PEEK, '1);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      quiet = (n % 250) >= 200;
      if (mirror.depth >= DEPTH) begin
        if ($urandom_range(0, 1)) climbing = 1'b0;
      end else if (mirror.depth < 2) begin
        if ($urandom_range(0, 1)) climbing = 1'b1;
      end else if ($urandom_range(0, 99) < 4) begin
        climbing = !climbing;
      end
      send_item(pick_action(climbing), pick_value());
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.awaited.size() != 0) begin
      $error("%0d results never arrived", mirror.awaited.size());
      mirror.failures++;
    end
    if (mirror.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
